// File: hw/rtl/rarm_pkg.sv
// Shared constants and saturating arithmetic for the range-add / range-min tree.
package rarm_pkg;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES;
  localparam int ADDR_W = $clog2(NODES);
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;

  localparam logic [VAL_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [VAL_W-1:0] EMPTY_ANSWER = 32'd1073741823;
  localparam logic [POS_W-1:0] TOP_POS      = POS_W'(LEAVES);

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/range_add_range_min_tree_core.sv
// Lazy segment tree, range add and range minimum, kept in two node memories.
// Operation: a query or add walks the tree one node at a time, with these steps per node
//   visited (read, push-down of pending add into both children, decide, return, and for
//   adds a combine on the way up). An empty query answers in the cycle after acceptance.
// Throughput: one item at a time; busy stays high until the walk ends.
// Reset: synchronous; afterwards a clearing pass zeroes all 2048 entries of both memories
//   with busy high. The result strobe lasts one cycle and cannot be held off.
module range_add_range_min_tree_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic [rarm_pkg::POS_W-1:0]        range_low,
  input  logic [rarm_pkg::POS_W-1:0]        range_high,
  input  logic signed [15:0]                delta,
  input  logic                              cfg_we,
  input  logic [rarm_pkg::POS_W-1:0]        cfg_wdata,
  output logic                              done,
  output logic signed [rarm_pkg::VAL_W-1:0] min_value
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD_NODE, S_PUSH, S_CH_RD, S_CH_WR,
    S_DECIDE, S_RETURN, S_COMB_RD, S_COMB_WR
  } state_t;

  state_t state;

  logic [rarm_pkg::POS_W-1:0]        leaves_in_use;
  logic [rarm_pkg::ADDR_W-1:0]       node;
  logic [rarm_pkg::ADDR_W-1:0]       ch;
  logic [rarm_pkg::ADDR_W-1:0]       clr_addr;
  logic [rarm_pkg::POS_W-1:0]        lo, hi, qa, qb;
  logic                              is_query;
  logic                              after_decide;
  logic signed [rarm_pkg::VAL_W-1:0] d_ext, acc, cur_nm, push_val;

  // node memories
  logic signed [rarm_pkg::VAL_W-1:0] nm_mem [rarm_pkg::NODES];
  logic signed [rarm_pkg::VAL_W-1:0] pd_mem [rarm_pkg::NODES];
  logic signed [rarm_pkg::VAL_W-1:0] nm_q, pd_q, nm_wd, pd_wd;
  logic [rarm_pkg::ADDR_W-1:0]       nm_ra, pd_ra, nm_wa, pd_wa;
  logic                              nm_we, pd_we;

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_mem[nm_wa] <= nm_wd;
    end
    nm_q <= nm_mem[nm_ra];
  end

  always_ff @(posedge clk) begin
    if (pd_we) begin
      pd_mem[pd_wa] <= pd_wd;
    end
    pd_q <= pd_mem[pd_ra];
  end

  // clipping of the incoming range
  logic [rarm_pkg::POS_W-1:0] top, a_clip, b_clip;
  logic                       empty;
  assign top    = (leaves_in_use > rarm_pkg::TOP_POS) ? rarm_pkg::TOP_POS : leaves_in_use;
  assign a_clip = (range_low == '0) ? rarm_pkg::POS_W'(1) : range_low;
  assign b_clip = (range_high > top) ? top : range_high;
  assign empty  = a_clip > b_clip;

  logic [rarm_pkg::POS_W-1:0]        size, mid;
  logic                              leaf, disjoint, full;
  logic [rarm_pkg::ADDR_W-1:0]       left_child;
  logic signed [rarm_pkg::VAL_W-1:0] pushed_nm, comb_nm;
  logic [rarm_pkg::POS_W:0]          lo_hi_sum;

  assign size       = hi - lo + rarm_pkg::POS_W'(1);
  assign lo_hi_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid        = lo_hi_sum[rarm_pkg::POS_W:1];
  assign leaf       = lo == hi;
  assign disjoint   = (lo > qb) || (hi < qa);
  assign full       = (qa <= lo) && (hi <= qb);
  assign left_child = {node[rarm_pkg::ADDR_W-2:0], 1'b0};
  assign pushed_nm  = rarm_pkg::sat_add(nm_q, pd_q);
  assign comb_nm    = rarm_pkg::smin(nm_q, cur_nm);

  always_comb begin
    nm_ra = node;
    pd_ra = node;
    nm_we = 1'b0;
    pd_we = 1'b0;
    nm_wa = node;
    pd_wa = node;
    nm_wd = pushed_nm;
    pd_wd = '0;
    unique case (state)
      S_CLEAR: begin
        nm_we = 1'b1;
        pd_we = 1'b1;
        nm_wa = clr_addr;
        pd_wa = clr_addr;
        nm_wd = '0;
      end
      S_PUSH: begin
        nm_we = pd_q != '0;
        pd_we = pd_q != '0;
      end
      S_CH_RD:   pd_ra = ch;
      S_CH_WR: begin
        pd_we = 1'b1;
        pd_wa = ch;
        pd_wd = rarm_pkg::sat_add(pd_q, push_val);
      end
      S_DECIDE: begin
        if (!disjoint && full && !is_query) begin
          nm_we = 1'b1;
          pd_we = 1'b1;
          nm_wd = rarm_pkg::sat_add(cur_nm, d_ext);
        end
      end
      S_COMB_RD: nm_ra = left_child;
      S_COMB_WR: begin
        nm_we = 1'b1;
        nm_wd = comb_nm;
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      leaves_in_use <= rarm_pkg::TOP_POS;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        leaves_in_use <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            qa       <= a_clip;
            qb       <= b_clip;
            is_query <= action;
            d_ext    <= {{16{delta[15]}}, delta};
            acc      <= rarm_pkg::VAL_MAX;
            node     <= rarm_pkg::ADDR_W'(1);
            lo       <= rarm_pkg::POS_W'(1);
            hi       <= rarm_pkg::TOP_POS;
            if (empty) begin
              if (action) begin
                done      <= 1'b1;
                min_value <= rarm_pkg::EMPTY_ANSWER;
              end
            end else begin
              state <= S_RD_NODE;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + rarm_pkg::ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_RD_NODE: state <= S_PUSH;
        S_PUSH: begin
          cur_nm       <= (pd_q != '0) ? pushed_nm : nm_q;
          push_val     <= pd_q;
          ch           <= left_child;
          after_decide <= 1'b1;
          state        <= (pd_q != '0 && !leaf) ? S_CH_RD : S_DECIDE;
        end
        S_CH_RD: state <= S_CH_WR;
        S_CH_WR: begin
          if (!ch[0]) begin
            ch    <= ch + rarm_pkg::ADDR_W'(1);
            state <= S_CH_RD;
          end else begin
            state <= after_decide ? S_DECIDE : S_RETURN;
          end
        end
        S_DECIDE: begin
          priority if (disjoint) begin
            state <= S_RETURN;
          end else if (full) begin
            if (is_query) begin
              acc   <= rarm_pkg::smin(acc, cur_nm);
              state <= S_RETURN;
            end else begin
              // apply the add here and, unless this is a leaf or the add is zero, pass it to both children
              cur_nm       <= rarm_pkg::sat_add(cur_nm, d_ext);
              push_val     <= d_ext;
              ch           <= left_child;
              after_decide <= 1'b0;
              state        <= (d_ext != '0 && !leaf) ? S_CH_RD : S_RETURN;
            end
          end else begin
            node  <= left_child;
            hi    <= mid;
            state <= S_RD_NODE;
          end
        end
        S_RETURN: begin
          priority if (node == rarm_pkg::ADDR_W'(1)) begin
            if (is_query) begin
              done      <= 1'b1;
              min_value <= acc;
            end
            state <= S_IDLE;
          end else if (!node[0]) begin
            node  <= node + rarm_pkg::ADDR_W'(1);
            lo    <= hi + rarm_pkg::POS_W'(1);
            hi    <= hi + size;
            state <= S_RD_NODE;
          end else begin
            node  <= node >> 1;
            lo    <= lo - size;
            state <= is_query ? S_RETURN : S_COMB_RD;
          end
        end
        S_COMB_RD: state <= S_COMB_WR;
        S_COMB_WR: begin
          cur_nm <= comb_nm;
          state  <= S_RETURN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rarm_chk.sv
// Port-level checks for the range-add / range-min tree, bound to the core module.
module rarm_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              action,
  input logic                              done,
  input logic signed [rarm_pkg::VAL_W-1:0] min_value
);

  // a result comes only from an accepted query or a walk in progress
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start && action))
    else $error("result without an item");

  // reset starts the clearing pass
  a_rst_clear: assert property (@(posedge clk)
    rst |=> busy)
    else $error("no clearing pass after reset");

  // nothing happens when idle and not started
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done)
    else $error("spurious result");

  // an add never gives a result straight away
  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    (!busy && start && !action) |=> !done)
    else $error("result from an add");

  // a strobed result carries a known value
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(min_value))
    else $error("unknown result value");

endmodule

bind range_add_range_min_tree_core rarm_chk u_rarm_chk (.*);

// File: sim/tb.sv
// Self-checking testbench for the lazy range-add / range-min tree core.
module tb;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} step_kind_t;
  typedef struct {
    step_kind_t                  kind;
    logic                        action;
    logic [rarm_pkg::POS_W-1:0]  lo;
    logic [rarm_pkg::POS_W-1:0]  hi;
    logic signed [15:0]          delta;
    logic [rarm_pkg::POS_W-1:0]  cfgv;
  } step_t;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  logic clk, rst, start, busy, action, cfg_we, done;
  logic [rarm_pkg::POS_W-1:0] range_low, range_high, cfg_wdata;
  logic signed [15:0] delta;
  logic signed [rarm_pkg::VAL_W-1:0] min_value;

  range_add_range_min_tree_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .range_low(range_low), .range_high(range_high), .delta(delta),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .min_value(min_value)
  );

  // predictor state
  logic signed [31:0] node_min [0:4*rarm_pkg::LEAVES-1] = '{default: '0};
  logic signed [31:0] node_pend [0:4*rarm_pkg::LEAVES-1] = '{default: '0};
  logic [rarm_pkg::POS_W-1:0] span_top = rarm_pkg::TOP_POS;

  step_t pend_steps[$];
  logic signed [31:0] want_min[$];
  int errors = 0;
  int gap = 0;
  int burst = 0;
  int quiet = 0;
  int stall = 0;

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic void tree_push(int n, int lo, int hi);
    logic signed [31:0] p;
    p = node_pend[n];
    if (p == 0) return;
    node_min[n] = clamp_add(node_min[n], p);
    if (lo != hi) begin
      node_pend[2*n]   = clamp_add(node_pend[2*n], p);
      node_pend[2*n+1] = clamp_add(node_pend[2*n+1], p);
    end
    node_pend[n] = 0;
  endfunction

  function automatic void tree_add(int n, int lo, int hi, int a, int b,
                                   logic signed [31:0] d);
    int mid;
    tree_push(n, lo, hi);
    if (lo > b || hi < a) return;
    if (a <= lo && hi <= b) begin
      node_pend[n] = clamp_add(node_pend[n], d);
      tree_push(n, lo, hi);
      return;
    end
    mid = lo + (hi - lo) / 2;
    tree_add(2*n, lo, mid, a, b, d);
    tree_add(2*n+1, mid + 1, hi, a, b, d);
    node_min[n] = (node_min[2*n] < node_min[2*n+1]) ? node_min[2*n] : node_min[2*n+1];
  endfunction

  function automatic logic signed [31:0] tree_min(int n, int lo, int hi, int a, int b);
    int mid;
    logic signed [31:0] x, y;
    tree_push(n, lo, hi);
    if (lo > b || hi < a) return 32'sh7FFF_FFFF;
    if (a <= lo && hi <= b) return node_min[n];
    mid = lo + (hi - lo) / 2;
    x = tree_min(2*n, lo, mid, a, b);
    y = tree_min(2*n+1, mid + 1, hi, a, b);
    return (x < y) ? x : y;
  endfunction

  function automatic void predict_item(step_t s);
    int a, b, top;
    logic signed [31:0] m;
    a = int'(s.lo);
    b = int'(s.hi);
    top = (int'(span_top) < rarm_pkg::LEAVES) ? int'(span_top) : rarm_pkg::LEAVES;
    if (a < 1) a = 1;
    if (b > top) b = top;
    if (s.action == ACT_ADD) begin
      if (a <= b) tree_add(1, 1, rarm_pkg::LEAVES, a, b, 32'(s.delta));
    end else begin
      m = (a > b) ? $signed(rarm_pkg::EMPTY_ANSWER)
                  : tree_min(1, 1, rarm_pkg::LEAVES, a, b);
      want_min.insert(want_min.size(), m);
    end
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] exp);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_item(logic act, int lo, int hi, int d);
    step_t s;
    s.kind = K_ITEM; s.action = act; s.lo = lo[rarm_pkg::POS_W-1:0];
    s.hi = hi[rarm_pkg::POS_W-1:0]; s.delta = d[15:0]; s.cfgv = '0;
    pend_steps.insert(pend_steps.size(), s);
  endtask

  task automatic add_cfg(int v);
    step_t s;
    s.kind = K_CFG; s.action = ACT_ADD; s.lo = '0; s.hi = '0; s.delta = '0;
    s.cfgv = v[rarm_pkg::POS_W-1:0];
    pend_steps.insert(pend_steps.size(), s);
  endtask

  task automatic add_drain();
    step_t s;
    s.kind = K_DRAIN; s.action = ACT_ADD; s.lo = '0; s.hi = '0; s.delta = '0;
    s.cfgv = '0;
    pend_steps.insert(pend_steps.size(), s);
  endtask

  task automatic add_random(int count, int top);
    int lo, hi, t, r;
    t = (top < 1) ? 1 : ((top > rarm_pkg::LEAVES) ? rarm_pkg::LEAVES : top);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        lo = $urandom_range(1, t);
        hi = ($urandom_range(0, 3) == 0) ? lo : $urandom_range(lo, t);
      end else begin
        // noise: anything the 11-bit fields hold
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end
      add_item(1'($urandom_range(0, 1)), lo, hi, $urandom_range(0, 65535));
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    logic nxt_start, nxt_we;
    step_t cur;
    nxt_we = 1'b0;
    if (rst) begin
      start <= 1'b0; cfg_we <= 1'b0; action <= ACT_ADD;
      range_low <= '0; range_high <= '0; delta <= '0; cfg_wdata <= '0;
      quiet = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        cur.kind = K_ITEM; cur.action = action; cur.lo = range_low;
        cur.hi = range_high; cur.delta = delta; cur.cfgv = '0;
        predict_item(cur);
        nxt_start = 1'b0;
        gap = pick_gap();
      end
      quiet = (start || busy) ? 0 : quiet + 1;
      if (!nxt_start && pend_steps.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else if (pend_steps[0].kind == K_ITEM) begin
          cur = pend_steps.pop_front();
          action <= cur.action; range_low <= cur.lo; range_high <= cur.hi;
          delta <= cur.delta;
          nxt_start = 1'b1;
        end else if (want_min.size() == 0 && quiet >= 16) begin
          cur = pend_steps.pop_front();
          if (cur.kind == K_CFG) begin
            nxt_we = 1'b1;
            cfg_wdata <= cur.cfgv;
            span_top = cur.cfgv;
          end
          quiet = 0;
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (want_min.size() == 0) begin
        report("unexpected result", min_value, 0);
      end else if (min_value !== want_min[0]) begin
        report("min_value", min_value, want_min[0]);
        void'(want_min.pop_front());
      end else begin
        void'(want_min.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || cfg_we) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  initial begin
    rst = 1'b1;

    // directed part
    add_item(ACT_QUERY, 1, 1024, 0);
    add_item(ACT_ADD, 1, 1024, 32767);
    add_item(ACT_ADD, 1, 512, -32768);
    add_item(ACT_QUERY, 1, 1, 0);
    add_item(ACT_QUERY, 1024, 1024, 0);
    add_item(ACT_QUERY, 513, 1024, 0);
    add_item(ACT_QUERY, 0, 2047, 0);
    add_item(ACT_QUERY, 700, 300, 0);        // low above high
    add_item(ACT_QUERY, 0, 0, 0);            // clipped to nothing
    add_item(ACT_QUERY, 2047, 2047, 0);      // beyond the top
    add_item(ACT_ADD, 1025, 2047, 1234);     // add over nothing
    add_item(ACT_ADD, 300, 300, -1);
    add_item(ACT_QUERY, 299, 301, 0);
    add_cfg(1);
    add_item(ACT_QUERY, 1, 1024, 0);
    add_item(ACT_ADD, 0, 2047, 5);
    add_item(ACT_QUERY, 2, 2, 0);
    add_cfg(0);                               // nothing in use
    add_item(ACT_QUERY, 1, 1024, 0);
    add_item(ACT_ADD, 1, 1024, 77);
    add_cfg(2047);                            // clipped to the full tree
    add_item(ACT_QUERY, 1, 2047, 0);
    add_item(ACT_QUERY, 1, 1, 0);
    // random phases
    add_cfg(1024); add_random(200, 1024);
    add_drain();   add_random(60, 1024);
    add_cfg(37);   add_random(120, 37);
    add_cfg(1);    add_random(40, 1);
    add_cfg(513);  add_random(150, 513);
    add_cfg(2);    add_random(40, 2);
    add_cfg($urandom_range(0, 2047)); add_random(60, 1024);
    add_cfg(1024); add_random(130, 1024);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pend_steps.size() > 0 || start) @(posedge clk);
    while (want_min.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
